>>> sv/tlce_pkg.sv
// Package for the character display cursor engine.
// Holds the payload structs, codes, controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlce_pkg;

  localparam int unsigned NUM_DIGITS    = 10;
  localparam int unsigned MAG_W         = 32;
  localparam int unsigned BCD_W         = 4 * NUM_DIGITS;
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned CONV_STEPS    = MAG_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(CONV_STEPS);
  localparam int unsigned DIG_W         = $clog2(NUM_DIGITS);

  localparam logic [2:0] LINE_COUNT_RST   = 3'd2;
  localparam logic [5:0] COLUMN_COUNT_RST = 6'd16;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] ADDR_ODD_ROW = 8'h40;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_INT   = 2'd1,
    OP_MOVE  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_HOME  = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_LINE_COUNT   = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PS_CHAR  = 2'd0,
    PS_MINUS = 2'd1,
    PS_DIGIT = 2'd2
  } put_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_LEAD,
    S_PUT,
    S_ADDR,
    S_MOVE,
    S_CLEAR,
    S_HOME
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         char_code;
    logic signed [31:0] number;
    logic [7:0]         target_column;
    logic [1:0]         target_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic     load;
    logic     conv_step;
    logic     dig_init;
    logic     dig_dec;
    logic     put;
    put_sel_e put_sel;
    logic     move;
    logic     clr_cursor;
    logic     emit;
    kind_e    kind;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic dig_zero;
    logic put_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/tlce_ctrl.sv
// Sequencing controller of the cursor engine.
// Walks each item through conversion, character puts and command emission.
// Depends on tlce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlce_ctrl
  import tlce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_opcode_i,
  output logic            in_ready_o,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  state_e   state_q, state_d;
  opcode_e  op_q, op_d;
  put_sel_e sel_q, sel_d;
  logic     addr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_CHAR;
      sel_q   <= PS_CHAR;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      sel_q   <= sel_d;
    end
  end

  assign addr_last = (op_q != OP_INT) || ((sel_q == PS_DIGIT) && sts_i.dig_zero);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    sel_d      = sel_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.put_sel = sel_q;
    cmd_o.kind    = KIND_DATA;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = opcode_e'(in_opcode_i);
          unique case (opcode_e'(in_opcode_i))
            OP_CHAR: begin
              sel_d   = PS_CHAR;
              state_d = S_PUT;
            end
            OP_INT:   state_d = S_CONV;
            OP_MOVE:  state_d = S_MOVE;
            OP_CLEAR: state_d = S_CLEAR;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = S_LEAD;
        end
      end
      S_LEAD: begin
        cmd_o.dig_init = 1'b1;
        sel_d   = sts_i.neg ? PS_MINUS : PS_DIGIT;
        state_d = S_PUT;
      end
      S_PUT: begin
        if (sts_i.put_ok) begin
          cmd_o.put  = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_DATA;
          state_d    = S_ADDR;
        end
      end
      S_ADDR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_ADDR;
          cmd_o.last = addr_last;
          if (addr_last) begin
            state_d = S_IDLE;
          end else begin
            if (sel_q == PS_MINUS) begin
              sel_d = PS_DIGIT;
            end else begin
              cmd_o.dig_dec = 1'b1;
            end
            state_d = S_PUT;
          end
        end
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_ADDR;
      end
      S_CLEAR: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.kind       = KIND_CLEAR;
          cmd_o.clr_cursor = 1'b1;
          state_d          = S_HOME;
        end
      end
      S_HOME: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_HOME;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tlce_dp.sv
// Datapath of the cursor engine: config registers, cursor state, binary to
// BCD conversion, address formation and the output register.
// Depends on tlce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlce_dp
  import tlce_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_data_i,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_idx_i,
  input  wire logic [5:0] cfg_data_i,
  input  wire cmd_t     cmd_i,
  output sts_t          sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  logic [2:0]        line_count_q;
  logic [5:0]        column_count_q;
  logic [7:0]        col_q, col_d;
  logic [2:0]        row_q, row_d;
  logic              wrapped_q, wrapped_d;

  logic [7:0]        char_q;
  logic [7:0]        tcol_q;
  logic [1:0]        trow_q;
  logic              neg_q;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [STEP_W-1:0] step_q;
  logic [DIG_W-1:0]  dig_q, lead;
  logic [3:0]        digit;

  logic [7:0]        put_char, col_a, address;
  logic [2:0]        row_a;
  logic              is_nl, wrap;

  logic              out_valid_q;
  out_item_t         out_q;
  logic              out_free;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= LINE_COUNT_RST;
      column_count_q <= COLUMN_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_COUNT:   line_count_q   <= cfg_data_i[2:0];
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // double dabble, BITS_PER_STEP bits per cycle
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = bcd_q;
    m = mag_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int n = 0; n < NUM_DIGITS; n++) begin
        if (b[n*4 +: 4] >= 4'd5) begin
          b[n*4 +: 4] = b[n*4 +: 4] + 4'd3;
        end
      end
      {b, m} = {b[BCD_W-2:0], m, 1'b0};
    end
    bcd_d = b;
    mag_d = m;
  end

  always_comb begin
    lead  = '0;
    digit = '0;
    for (int n = 0; n < NUM_DIGITS; n++) begin
      if (bcd_q[n*4 +: 4] != 4'd0) begin
        lead = DIG_W'(n);
      end
      if (dig_q == DIG_W'(n)) begin
        digit = bcd_q[n*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= in_data_i.char_code;
      tcol_q <= in_data_i.target_column;
      trow_q <= in_data_i.target_row;
      neg_q  <= in_data_i.number[MAG_W-1];
      mag_q  <= in_data_i.number[MAG_W-1] ? (~MAG_W'(in_data_i.number) + MAG_W'(1))
                                          : MAG_W'(in_data_i.number);
      bcd_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.conv_step) begin
      mag_q  <= mag_d;
      bcd_q  <= bcd_d;
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.dig_init) begin
      dig_q <= lead;
    end else if (cmd_i.dig_dec) begin
      dig_q <= dig_q - DIG_W'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.put_sel)
      PS_CHAR:  put_char = char_q;
      PS_MINUS: put_char = CHAR_MINUS;
      PS_DIGIT: put_char = CHAR_ZERO + {4'd0, digit};
      default:  put_char = char_q;
    endcase
  end

  // cursor advance for one character
  assign is_nl = (put_char == CHAR_NEWLINE);
  assign col_a = is_nl ? (wrapped_q ? col_q : {2'b00, column_count_q}) : (col_q + 8'd1);
  assign wrap  = (col_a >= {2'b00, column_count_q});
  assign row_a = wrap ? (row_q + 3'd1) : row_q;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    wrapped_d = wrapped_q;
    if (cmd_i.put) begin
      col_d     = wrap ? 8'd0 : col_a;
      row_d     = (row_a >= line_count_q) ? 3'd0 : row_a;
      wrapped_d = wrap ? !is_nl : wrapped_q;
    end else if (cmd_i.move) begin
      col_d = tcol_q;
      row_d = {1'b0, trow_q};
    end else if (cmd_i.clr_cursor) begin
      col_d = 8'd0;
      row_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      wrapped_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      wrapped_q <= wrapped_d;
    end
  end

  assign address = {2'b00, col_q[5:0]}
                 + (row_q[0] ? ADDR_ODD_ROW : 8'd0)
                 + (row_q[1] ? {2'b00, column_count_q} : 8'd0);

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && !(cmd_i.kind == KIND_DATA && is_nl)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && !(cmd_i.kind == KIND_DATA && is_nl)) begin
      out_q.kind <= cmd_i.kind;
      out_q.last <= cmd_i.last;
      case (cmd_i.kind)
        KIND_DATA: out_q.value <= put_char;
        KIND_ADDR: out_q.value <= address;
        default:   out_q.value <= 8'd0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.conv_done = (step_q == STEP_W'(CONV_STEPS - 1));
  assign sts_o.neg       = neg_q;
  assign sts_o.dig_zero  = (dig_q == '0);
  assign sts_o.put_ok    = is_nl || out_free;
  assign sts_o.out_free  = out_free;

endmodule

`default_nettype wire

>>> sv/text_lcd_cursor_engine.sv
// Character display cursor engine, top level. Depends on tlce_pkg, tlce_ctrl, tlce_dp.
// Integers go through BCD conversion at 2 bits per cycle before their first result.
// Throughput: one item at a time; an integer's results leave the output register one per
// cycle while out_ready_i stays high.
// Reset: cursor at column 0 row 0, wrap flag clear, line_count 2, column_count 16.
`timescale 1ns / 1ps
`default_nettype none

module text_lcd_cursor_engine
  import tlce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [5:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  tlce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sv/tlce_chk.sv
// Port-level checker for the cursor engine, bound to the top level.
// Depends on tlce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlce_chk
  import tlce_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire in_item_t   in_data_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire out_item_t  out_data_o,
  input wire logic       cfg_we_i,
  input wire logic       cfg_idx_i,
  input wire logic [5:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new transfer taken while item in progress");

  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_DATA) |-> !out_data_o.last)
    else $error("data byte flagged as last");

  a_clear_then_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_data_o.kind == KIND_CLEAR)
    |=> out_valid_o && (out_data_o.kind == KIND_HOME) && out_data_o.last)
    else $error("clear not followed by home");

endmodule

bind text_lcd_cursor_engine tlce_chk u_chk (.*);

`default_nettype wire
